// ===== rtl/dis_pkg.sv =====
// shared types and codes for the disjoint interval set
package dis_pkg;

    localparam int unsigned BOUND_W = 31;
    localparam int unsigned TOTAL_W = 32;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_REMOVE = 2'd1,
        K_QUERY  = 2'd2,
        K_UNUSED = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_FIN
    } t_state;

    typedef logic [BOUND_W-1:0] t_bound;

    // request held for the whole operation
    typedef struct packed {
        logic [1:0] kind;
        t_bound     lo;
        t_bound     hi;
        logic       off;
    } t_req;

    typedef struct packed {
        logic merge;
        logic split;
        logic le_lo;
        logic cov_hi;
    } t_cell_flags;

    typedef struct packed {
        logic   pop;
        logic   push;
        t_bound s;
        t_bound e;
        logic   done;
    } t_head_out;

endpackage

// ===== rtl/dis_ifs.sv =====
// request and response channels of the interval set
interface dis_in_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [30:0]          lo;
    logic [30:0]          hi;
    modport source (output valid, kind, lo, hi, input ready);
    modport sink (input valid, kind, lo, hi, output ready);
endinterface

interface dis_out_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic                 contained;
    logic [31:0]          covered_total;
    modport source (output valid, status, contained, covered_total, input ready);
    modport sink (input valid, status, contained, covered_total, output ready);
endinterface

// ===== rtl/dis_cell.sv =====
// one table entry: holds an interval, shifts toward the head, compares against the request
module dis_cell (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic                 i_shift,
    input  dis_pkg::t_bound      i_ld_s,
    input  dis_pkg::t_bound      i_ld_e,
    input  dis_pkg::t_bound      i_nx_s,
    input  dis_pkg::t_bound      i_nx_e,
    input  logic                 i_valid,
    input  dis_pkg::t_req        i_req,
    output dis_pkg::t_bound      o_s,
    output dis_pkg::t_bound      o_e,
    output dis_pkg::t_cell_flags o_flags
);
    dis_pkg::t_bound r_s, r_e;
    logic [31:0] s32, e32, lo32, hi32, off32;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s <= i_ld_s;
            r_e <= i_ld_e;
        end else if (i_shift) begin
            r_s <= i_nx_s;
            r_e <= i_nx_e;
        end
    end

    always_comb begin
        s32   = {1'b0, r_s};
        e32   = {1'b0, r_e};
        lo32  = {1'b0, i_req.lo};
        hi32  = {1'b0, i_req.hi};
        off32 = {31'd0, i_req.off};
        // overlapping, or touching in discrete mode
        o_flags.merge  = i_valid && !(e32 + off32 < lo32) && !(s32 > hi32 + off32);
        o_flags.split  = i_valid && (r_s < i_req.lo) && (r_e > i_req.hi);
        o_flags.le_lo  = i_valid && (r_s <= i_req.lo);
        o_flags.cov_hi = (i_req.hi <= r_e);
    end

    assign o_s = r_s;
    assign o_e = r_e;
endmodule

// ===== rtl/dis_head.sv =====
// head merge/split unit: pops one entry a cycle unless pushing a held piece; appends results
module dis_head #(
    parameter int unsigned CNT_W = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  dis_pkg::t_req      i_req,
    input  logic [CNT_W-1:0]   i_count,
    input  logic [31:0]        i_total,
    input  dis_pkg::t_bound    i_s,
    input  dis_pkg::t_bound    i_e,
    output dis_pkg::t_head_out o_ctl,
    output logic [31:0]        o_total
);
    logic               r_busy, n_busy;
    logic [CNT_W-1:0]   r_left, n_left;
    logic               r_placed, n_placed;
    dis_pkg::t_bound    r_nl, n_nl, r_nr, n_nr;
    logic               r_pv, n_pv;
    dis_pkg::t_bound    r_ps, n_ps, r_pe, n_pe;
    logic [31:0]        r_total, n_total;
    logic [31:0]        s32, e32, lo32, hi32, off32, len;
    logic               below, above, cut_l, cut_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_pv   <= n_pv;
        end
        r_left   <= n_left;
        r_placed <= n_placed;
        r_nl     <= n_nl;
        r_nr     <= n_nr;
        r_ps     <= n_ps;
        r_pe     <= n_pe;
        r_total  <= n_total;
    end

    always_comb begin
        s32   = {1'b0, i_s};
        e32   = {1'b0, i_e};
        lo32  = {1'b0, i_req.lo};
        hi32  = {1'b0, i_req.hi};
        off32 = {31'd0, i_req.off};
        len   = e32 - s32 + off32;
        below = (e32 + off32 < lo32);
        above = (s32 > hi32 + off32);
        cut_l = (i_s < i_req.lo);
        cut_r = (i_e > i_req.hi);

        n_busy   = r_busy;
        n_left   = r_left;
        n_placed = r_placed;
        n_nl     = r_nl;
        n_nr     = r_nr;
        n_pv     = r_pv;
        n_ps     = r_ps;
        n_pe     = r_pe;
        n_total  = r_total;
        o_ctl    = '0;

        if (r_busy) begin
            if (r_pv) begin
                o_ctl.push = 1'b1;
                o_ctl.s    = r_ps;
                o_ctl.e    = r_pe;
                n_pv       = 1'b0;
            end else if (r_left != '0) begin
                o_ctl.pop = 1'b1;
                n_left    = r_left - CNT_W'(1);
                if (i_req.kind == dis_pkg::K_INSERT) begin
                    if (below) begin
                        o_ctl.push = 1'b1;
                        o_ctl.s    = i_s;
                        o_ctl.e    = i_e;
                    end else if (above) begin
                        o_ctl.push = 1'b1;
                        if (!r_placed) begin
                            o_ctl.s  = r_nl;
                            o_ctl.e  = r_nr;
                            n_placed = 1'b1;
                            n_pv     = 1'b1;
                            n_ps     = i_s;
                            n_pe     = i_e;
                        end else begin
                            o_ctl.s = i_s;
                            o_ctl.e = i_e;
                        end
                    end else begin
                        if (i_s < r_nl) n_nl = i_s;
                        if (i_e > r_nr) n_nr = i_e;
                        n_total = r_total - len;
                    end
                end else begin
                    if ((i_e < i_req.lo) || (i_s > i_req.hi)) begin
                        o_ctl.push = 1'b1;
                        o_ctl.s    = i_s;
                        o_ctl.e    = i_e;
                    end else begin
                        n_total = r_total - len
                                + (cut_l ? lo32 - s32 : 32'd0)
                                + (cut_r ? e32 - hi32 : 32'd0);
                        if (cut_l) begin
                            o_ctl.push = 1'b1;
                            o_ctl.s    = i_s;
                            o_ctl.e    = i_req.lo - dis_pkg::BOUND_W'(i_req.off);
                            if (cut_r) begin
                                // split: right piece goes out next cycle
                                n_pv = 1'b1;
                                n_ps = i_req.hi + dis_pkg::BOUND_W'(i_req.off);
                                n_pe = i_e;
                            end
                        end else if (cut_r) begin
                            o_ctl.push = 1'b1;
                            o_ctl.s    = i_req.hi + dis_pkg::BOUND_W'(i_req.off);
                            o_ctl.e    = i_e;
                        end
                    end
                end
            end else begin
                o_ctl.done = 1'b1;
                n_busy     = 1'b0;
                if (i_req.kind == dis_pkg::K_INSERT) begin
                    n_total = r_total + ({1'b0, r_nr} - {1'b0, r_nl} + off32);
                    if (!r_placed) begin
                        o_ctl.push = 1'b1;
                        o_ctl.s    = r_nl;
                        o_ctl.e    = r_nr;
                    end
                end
            end
        end

        if (i_start) begin
            n_busy   = 1'b1;
            n_left   = i_count;
            n_total  = i_total;
            n_nl     = i_req.lo;
            n_nr     = i_req.hi;
            n_placed = 1'b0;
            n_pv     = 1'b0;
        end
    end

    assign o_total = n_total;
endmodule

// ===== rtl/disjoint_interval_set.sv =====
// top level of the disjoint interval set: cell chain, head unit and control
// Holds up to MAX_INTERVALS sorted disjoint intervals in a chain of cells and the count of
// covered points. One item is taken at a time. A query, a rejected range or a full-table
// rejection is settled in S_CHECK and its result is loaded into the output register from
// S_FIN, after which the next item can be taken. An insert or remove streams every stored
// interval once through the head unit, one a cycle except while the head writes out a held
// piece (when a remove splits an interval or an insert lands between stored intervals), then
// finishes, and its result goes out from S_FIN. A result left waiting holds the next item in
// the output stage. The table-full check and the containment query are done by all cells in
// parallel. The mode register r_mode resets to 1 and is written through i_cfg_we and
// i_cfg_wdata, by the user only while the block is idle; the block does not enforce this.
module disjoint_interval_set #(
    parameter int unsigned MAX_INTERVALS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    dis_in_if.sink     i_req,
    dis_out_if.source  o_rsp
);
    localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int unsigned IDX_W = $clog2(MAX_INTERVALS);

    dis_pkg::t_state      r_state, n_state;
    dis_pkg::t_req        r_req;
    logic                 r_mode;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [31:0]          r_total, n_total;
    logic [1:0]           r_status, n_status;
    logic                 r_cont, n_cont;
    logic                 r_ov, n_ov;
    logic [1:0]           r_o_status;
    logic                 r_o_cont;
    logic [31:0]          r_o_total;
    logic                 load_out, start, bad, full, any_merge, any_split, found;
    logic [IDX_W-1:0]     wptr;

    dis_pkg::t_bound      cs [MAX_INTERVALS];
    dis_pkg::t_bound      ce [MAX_INTERVALS];
    dis_pkg::t_cell_flags fl [MAX_INTERVALS];
    dis_pkg::t_head_out   hd;
    logic [31:0]          head_total;

    assign wptr = IDX_W'(r_cnt - CNT_W'(hd.pop));

    for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_cell
        dis_cell u_cell (
            .i_clk   (i_clk),
            .i_load  (hd.push && (wptr == IDX_W'(k))),
            .i_shift (hd.pop),
            .i_ld_s  (hd.s),
            .i_ld_e  (hd.e),
            .i_nx_s  (cs[(k + 1) % MAX_INTERVALS]),
            .i_nx_e  (ce[(k + 1) % MAX_INTERVALS]),
            .i_valid (r_cnt > CNT_W'(k)),
            .i_req   (r_req),
            .o_s     (cs[k]),
            .o_e     (ce[k]),
            .o_flags (fl[k])
        );
    end

    dis_head #(.CNT_W(CNT_W)) u_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (r_req),
        .i_count (r_cnt),
        .i_total (r_total),
        .i_s     (cs[0]),
        .i_e     (ce[0]),
        .o_ctl   (hd),
        .o_total (head_total)
    );

    always_comb begin
        any_merge = 1'b0;
        any_split = 1'b0;
        found     = 1'b0;
        for (int k = 0; k < MAX_INTERVALS; k++) begin
            any_merge = any_merge | fl[k].merge;
            any_split = any_split | fl[k].split;
            // last stored interval whose start is not above lo
            if (k == MAX_INTERVALS - 1) begin
                found = found | (fl[k].le_lo && fl[k].cov_hi);
            end else begin
                found = found | (fl[k].le_lo && !fl[k + 1].le_lo && fl[k].cov_hi);
            end
        end
    end

    always_comb begin
        bad = !(({1'b0, r_req.lo}) < ({1'b0, r_req.hi} + {31'd0, r_req.off}))
            || !((r_req.kind == dis_pkg::K_INSERT) || (r_req.kind == dis_pkg::K_REMOVE)
                 || (r_req.kind == dis_pkg::K_QUERY));
        full = (r_cnt == CNT_W'(MAX_INTERVALS))
            && (((r_req.kind == dis_pkg::K_INSERT) && !any_merge)
                || ((r_req.kind == dis_pkg::K_REMOVE) && any_split));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dis_pkg::S_IDLE;
            r_mode  <= 1'b1;
            r_cnt   <= '0;
            r_total <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_mode <= i_cfg_wdata;
            r_cnt   <= n_cnt;
            r_total <= n_total;
            r_ov    <= n_ov;
        end
        r_status <= n_status;
        r_cont   <= n_cont;
        if (i_req.valid && i_req.ready) begin
            r_req.kind <= i_req.kind;
            r_req.lo   <= i_req.lo;
            r_req.hi   <= i_req.hi;
            r_req.off  <= r_mode;
        end
        if (load_out) begin
            r_o_status <= r_status;
            r_o_cont   <= r_cont;
            r_o_total  <= r_total;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt + CNT_W'(hd.push) - CNT_W'(hd.pop);
        n_total  = r_total;
        n_status = r_status;
        n_cont   = r_cont;
        start    = 1'b0;
        load_out = 1'b0;
        n_ov     = r_ov && !o_rsp.ready;
        case (r_state)
            dis_pkg::S_IDLE: begin
                if (i_req.valid) n_state = dis_pkg::S_CHECK;
            end
            dis_pkg::S_CHECK: begin
                n_cont  = 1'b0;
                n_state = dis_pkg::S_FIN;
                if (bad) begin
                    n_status = dis_pkg::ST_INVALID;
                end else if (r_req.kind == dis_pkg::K_QUERY) begin
                    n_status = dis_pkg::ST_OK;
                    n_cont   = found;
                end else if (full) begin
                    n_status = dis_pkg::ST_FULL;
                end else begin
                    n_status = dis_pkg::ST_OK;
                    start    = 1'b1;
                    n_state  = dis_pkg::S_RUN;
                end
            end
            dis_pkg::S_RUN: begin
                if (hd.done) begin
                    n_total = head_total;
                    n_state = dis_pkg::S_FIN;
                end
            end
            dis_pkg::S_FIN: begin
                if (!r_ov || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_ov     = 1'b1;
                    n_state  = dis_pkg::S_IDLE;
                end
            end
            default: n_state = dis_pkg::S_IDLE;
        endcase
    end

    assign i_req.ready         = (r_state == dis_pkg::S_IDLE);
    assign o_rsp.valid         = r_ov;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.contained     = r_o_cont;
    assign o_rsp.covered_total = r_o_total;
endmodule

// ===== bench/dis_checker.sv =====
// checker for the interval set: predicts each result and compares it with the block
module dis_checker #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    dis_in_if    req,
    dis_out_if   rsp,
    output int   o_errors,
    output int   o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic        contained;
        logic [31:0] total;
    } t_outcome;

    t_outcome    outcome_q[$];

    // table as seen by the predictor
    longint      span_lo [CAPACITY];
    longint      span_hi [CAPACITY];
    int          span_cnt;
    logic [31:0] covered;
    logic        mode;

    // table being rebuilt by an insert or remove
    longint      fresh_lo [CAPACITY+2];
    longint      fresh_hi [CAPACITY+2];
    int          fresh_n;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        span_cnt  = 0;
        covered   = '0;
        mode      = 1'b1;
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        o_errors++;
    endtask

    function automatic void stash(input longint s, input longint e);
        if (fresh_n < CAPACITY + 2) begin
            fresh_lo[fresh_n] = s;
            fresh_hi[fresh_n] = e;
        end
        fresh_n++;
    endfunction

    function automatic t_outcome predict_step(input logic [1:0] k, input longint lo,
                                              input longint hi);
        t_outcome    r;
        longint      off;
        longint      nl;
        longint      nr;
        longint      s;
        longint      e;
        logic [31:0] tot;
        bit          placed;
        int          found;
        off         = longint'(mode);
        r.status    = dis_pkg::ST_OK;
        r.contained = 1'b0;
        tot         = covered;
        fresh_n     = 0;
        if (k == dis_pkg::K_UNUSED || !(lo < hi + off)) begin
            r.status = dis_pkg::ST_INVALID;
        end else if (k == dis_pkg::K_QUERY) begin
            found = -1;
            for (int i = 0; i < span_cnt; i++)
                if (span_lo[i] <= lo) found = i;
            r.contained = (found >= 0) && (hi <= span_hi[found]);
        end else begin
            if (k == dis_pkg::K_INSERT) begin
                nl     = lo;
                nr     = hi;
                placed = 0;
                for (int i = 0; i < span_cnt; i++) begin
                    s = span_lo[i];
                    e = span_hi[i];
                    if (e < lo - off) begin
                        stash(s, e);
                    end else if (s > hi + off) begin
                        if (!placed) begin
                            stash(nl, nr);
                            placed = 1;
                        end
                        stash(s, e);
                    end else begin
                        if (s < nl) nl = s;
                        if (e > nr) nr = e;
                        tot -= 32'(e - s + off);
                    end
                end
                if (!placed) stash(nl, nr);
                tot += 32'(nr - nl + off);
            end else begin
                for (int i = 0; i < span_cnt; i++) begin
                    s = span_lo[i];
                    e = span_hi[i];
                    if (e < lo || s > hi) begin
                        stash(s, e);
                    end else begin
                        tot -= 32'(e - s + off);
                        if (s < lo) begin
                            stash(s, lo - off);
                            tot += 32'(lo - s);
                        end
                        if (e > hi) begin
                            stash(hi + off, e);
                            tot += 32'(e - hi);
                        end
                    end
                end
            end
            if (fresh_n > CAPACITY) begin
                r.status = dis_pkg::ST_FULL;
            end else begin
                for (int i = 0; i < fresh_n; i++) begin
                    span_lo[i] = fresh_lo[i];
                    span_hi[i] = fresh_hi[i];
                end
                span_cnt = fresh_n;
                covered  = tot;
            end
        end
        r.total = covered;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            span_cnt = 0;
            covered  = '0;
            mode     = 1'b1;
            outcome_q.delete();
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (outcome_q.size() == 0) begin
                    report("result with no item waiting");
                end else begin
                    want = outcome_q.pop_front();
                    if (rsp.status !== want.status)
                        report($sformatf("status %0d, expected %0d", rsp.status, want.status));
                    if (rsp.contained !== want.contained)
                        report($sformatf("contained %0d, expected %0d",
                                         rsp.contained, want.contained));
                    if (rsp.covered_total !== want.total)
                        report($sformatf("covered_total %0d, expected %0d",
                                         rsp.covered_total, want.total));
                end
            end
            if (req.valid && req.ready)
                outcome_q.push_back(predict_step(req.kind, longint'(req.lo), longint'(req.hi)));
            if (i_cfg_we) mode = i_cfg_wdata;
        end
        o_pending = outcome_q.size();
    end

endmodule

// ===== bench/tb_disjoint_interval_set.sv =====
// testbench top for the interval set: stimulus, flow control and verdict
module tb_disjoint_interval_set;

    localparam logic [30:0] TOP_BOUND   = 31'h7FFFFFFE;
    localparam int          QUIET_LIMIT = 5000;
    localparam int          HOLD_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;
    int   idle_pct;
    int   stall_pct;
    int   hold_go;
    int   hold_seen;
    int   hold_left;
    int   quiet;
    int   errors;
    int   pending;

    dis_in_if  req_if ();
    dis_out_if rsp_if ();

    disjoint_interval_set #(.MAX_INTERVALS(64)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    dis_checker #(.CAPACITY(64)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .req         (req_if),
        .rsp         (rsp_if),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        req_if.valid  = 1'b0;
        req_if.kind   = dis_pkg::K_INSERT;
        req_if.lo     = '0;
        req_if.hi     = '0;
        rsp_if.ready  = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_go       = 0;
        hold_seen     = 0;
        hold_left     = 0;
        quiet         = 0;
    end

    always #2 i_clk = ~i_clk;

    // receiver: random stalls plus one long hold-off in the last phase
    always @(posedge i_clk) begin
        if (hold_go != hold_seen) begin
            hold_seen    <= hold_go;
            hold_left    <= HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic offer(input logic [1:0] k, input logic [30:0] lo, input logic [30:0] hi);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.kind  <= k;
        req_if.lo    <= lo;
        req_if.hi    <= hi;
        do begin
            @(negedge i_clk);
            taken = req_if.ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic m);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_item();
        logic [30:0] lo;
        logic [30:0] hi;
        logic [30:0] t;
        logic [1:0]  k;
        int          p;
        if ($urandom_range(99) < 10) begin
            lo = 31'($urandom_range(TOP_BOUND, 0));
            hi = 31'($urandom_range(TOP_BOUND, 0));
            if (lo > hi) begin
                t  = lo;
                lo = hi;
                hi = t;
            end
        end else begin
            lo = 31'($urandom_range(3000));
            hi = lo + 31'($urandom_range(60));
        end
        if ($urandom_range(99) < 5) begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        p = $urandom_range(99);
        if (p < 45) k = dis_pkg::K_INSERT;
        else if (p < 75) k = dis_pkg::K_REMOVE;
        else if (p < 95) k = dis_pkg::K_QUERY;
        else if (p < 98) k = dis_pkg::K_UNUSED;
        else begin
            // wipe everything now and then so the table keeps room
            k  = dis_pkg::K_REMOVE;
            lo = '0;
            hi = TOP_BOUND;
        end
        offer(k, lo, hi);
    endtask

    initial begin
        int idle_set  [5] = '{0, 54, 0, 23, 0};
        int stall_set [5] = '{0, 0, 54, 23, 0};
        bit mode_set  [5] = '{1, 0, 1, 0, 1};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // closed ranges after reset
        offer(dis_pkg::K_INSERT, '0, TOP_BOUND);
        offer(dis_pkg::K_QUERY, 31'd5, 31'd5);
        offer(dis_pkg::K_QUERY, '0, TOP_BOUND);
        offer(dis_pkg::K_REMOVE, 31'd10, 31'd20);
        offer(dis_pkg::K_QUERY, 31'd5, 31'd25);
        offer(dis_pkg::K_REMOVE, '0, TOP_BOUND);
        offer(dis_pkg::K_INSERT, 31'd5, 31'd5);
        offer(dis_pkg::K_INSERT, 31'd6, 31'd9);
        offer(dis_pkg::K_INSERT, 31'd20, 31'd30);
        offer(dis_pkg::K_QUERY, 31'd20, 31'd30);
        offer(dis_pkg::K_QUERY, 31'd2, 31'd3);
        offer(dis_pkg::K_INSERT, 31'd9, 31'd3);
        offer(dis_pkg::K_UNUSED, 31'd1, 31'd2);
        offer(dis_pkg::K_REMOVE, 31'd4, 31'd4);
        offer(dis_pkg::K_REMOVE, 31'd7, 31'd7);
        // fill the table past its capacity with isolated points
        for (int i = 0; i < 70; i++)
            offer(dis_pkg::K_INSERT, 31'(100 + 3 * i), 31'(100 + 3 * i));
        offer(dis_pkg::K_REMOVE, 31'd101, 31'd101);
        offer(dis_pkg::K_REMOVE, 31'd103, 31'd103);

        // half-open ranges, keeping the stored bounds from closed mode
        set_mode(1'b0);
        offer(dis_pkg::K_INSERT, 31'd40, 31'd40);
        offer(dis_pkg::K_INSERT, 31'd40, 31'd50);
        offer(dis_pkg::K_INSERT, 31'd50, 31'd60);
        offer(dis_pkg::K_QUERY, 31'd40, 31'd60);
        offer(dis_pkg::K_REMOVE, 31'd45, 31'd46);
        offer(dis_pkg::K_REMOVE, '0, TOP_BOUND);

        for (int ph = 0; ph < 5; ph++) begin
            set_mode(mode_set[ph]);
            idle_pct  = idle_set[ph];
            stall_pct = stall_set[ph];
            if (ph == 4) hold_go = hold_go + 1;
            for (int n = 0; n < 150; n++)
                random_item();
        end

        drain();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== disjoint_interval_set.f =====
rtl/dis_pkg.sv
rtl/dis_ifs.sv
rtl/dis_cell.sv
rtl/dis_head.sv
rtl/disjoint_interval_set.sv
bench/dis_checker.sv
bench/tb_disjoint_interval_set.sv
